FILE: hw/rtl/fope_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fope_pkg
// shared types, constants and helpers of the first-order plant emulator
// ----------------------------------------------------------------------------
package fope_pkg;

    // operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TAU = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE   = 2'd2;

    localparam int CFG_DATA_W = 24;

    // configuration reset values
    localparam logic [23:0] GAIN_RESET    = 24'd65536;
    localparam logic [23:0] INV_TAU_RESET = 24'd65536;
    localparam logic [23:0] NOISE_RESET   = 24'd0;

    // noise generator
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // output clamp, +/-200.0 in q.16
    localparam logic signed [24:0] Y_MAX = 25'sd13107200;
    localparam logic signed [24:0] Y_MIN = -25'sd13107200;

    typedef struct packed {
        logic               operation;
        logic [2:0]         channel;
        logic signed [31:0] drive;
        logic [23:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [24:0] plant_output;
        logic               rejected;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear_all;
        logic do_mul;
        logic do_diff;
        logic do_prod;
        logic do_sum;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_reject;
    } t_status;

    // per-channel noise seed
    function automatic logic [31:0] fope_seed(input int idx);
        logic [31:0] seed;
        case (idx)
            0:       seed = 32'h1234ABCD;
            1:       seed = 32'h5678DEFE;
            2:       seed = 32'h9ABC1234;
            default: seed = 32'h0;
        endcase
        return seed;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/first_order_plant_emulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_order_plant_emulator_unit
// multi-channel first-order lag plant with per-channel lcg noise
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) takes one request: a step of one
// channel or a clear of every channel output. output channel (o_out_valid /
// i_out_ready) returns one result per request: the new plant output in q9.16
// and a rejected flag. config channel (i_cfg_valid / o_cfg_ready) writes gain,
// inverse time constant and noise amplitude by index; it is always ready and
// is meant to be written only while no request is in flight.
// a step request passes, in order, the gain and dt multiplies, difference and
// noise, two split diff*factor products, sum and clamp, and the result
// register; clear and rejected requests go straight to the result register.
// the sequencer visits each stage once per step request. a new request is taken
// as soon as the previous result sits in the output register, even if the
// receiver has not taken it yet.
// reset: synchronous, active low; channel outputs go to zero, noise generators reload
// their seeds, config registers return to gain 1.0, 1/tau 1.0, amplitude 0.
// when the receiver stalls, the finished result holds in the output register
// and the next request waits in the delivery stage until the slot frees up.
// ----------------------------------------------------------------------------
module first_order_plant_emulator_unit
    import fope_pkg::*;
#(
    parameter int CHANNELS = 3
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    // config channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // config writes go straight into the registers, no backpressure
    assign o_cfg_ready = 1'b1;

    // sequencer: walks one step through the datapath stages
    fope_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath: channel state, multipliers, clamp and result register
    fope_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/fope_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fope_ctrl
// sequencer of one plant step and owner of the result valid
// ----------------------------------------------------------------------------
module fope_ctrl
    import fope_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_DIFF = 6'b000100,
        S_MUL2 = 6'b001000,
        S_SUM  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_clear) begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_DONE;
                    end else if (i_status.is_reject) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.do_diff = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.do_prod = 1'b1;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result register is never overwritten while it still holds a waiting result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    // a valid step request enters the multiply stage
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_status.is_clear && !i_status.is_reject) |=> (r_state == S_MUL1))
        else $error("step request did not start the datapath");

    // outputs are cleared only when a clear request is taken
    a_clear_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear_all |-> (accept && i_status.is_clear))
        else $error("clear issued outside a clear request");

    // the sum stage always hands over to result delivery
    a_sum_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> (r_state == S_DONE))
        else $error("sum stage not followed by delivery");

endmodule
`default_nettype wire

FILE: hw/rtl/fope_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fope_dp
// plant datapath: config registers, channel state, multipliers and clamp
// ----------------------------------------------------------------------------
module fope_dp
    import fope_pkg::*;
#(
    parameter int CHANNELS = 3
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output t_out_item                  o_out_item
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

    // configuration
    logic signed [23:0] r_gain;
    logic [23:0]        r_inv_tau;
    logic [23:0]        r_amp;

    // channel state
    logic signed [25:0] r_level [CHANNELS];
    logic [31:0]        r_lcg   [CHANNELS];

    // working registers
    t_in_item           r_in;
    logic               r_reject;
    logic               r_zero;
    logic signed [39:0] r_ku;
    logic [31:0]        r_factor;
    logic [31:0]        r_lcg_next;
    logic signed [25:0] r_y_old;
    logic signed [40:0] r_diff;
    logic signed [25:0] r_noise;
    logic signed [57:0] r_p_hi;
    logic signed [41:0] r_p_lo;
    logic signed [24:0] r_y_new;
    t_out_item          r_out_item;

    logic [CH_W-1:0]    ch_idx;
    logic signed [55:0] ku_prod;
    logic [47:0]        factor_prod;
    logic [31:0]        lcg_next;
    logic signed [15:0] unit_sample;
    logic signed [40:0] noise_prod;
    logic signed [57:0] p_hi;
    logic signed [57:0] p_lo;
    logic signed [59:0] y_sum;
    logic signed [24:0] y_clamp;

    assign ch_idx = r_in.channel[CH_W-1:0];

    // request decode
    assign o_status.is_clear  = (i_in_item.operation == OP_CLEAR);
    assign o_status.is_reject = (i_in_item.operation == OP_STEP) &&
                                (({1'b0, i_in_item.channel} >= CH_LIMIT) ||
                                 (i_in_item.time_step == 24'd0));

    assign ku_prod     = r_gain * $signed(r_in.drive);
    assign factor_prod = r_inv_tau * r_in.time_step;
    assign lcg_next    = r_lcg[ch_idx] * LCG_MUL + LCG_ADD;

    // bits 23:8 minus 32768 is the same as flipping the top bit
    assign unit_sample = $signed({~r_lcg_next[23], r_lcg_next[22:8]});
    assign noise_prod  = $signed({1'b0, r_amp}) * unit_sample;

    // diff * factor split in two 16-bit halves of the factor
    assign p_hi = r_diff * $signed({1'b0, r_factor[31:16]});
    assign p_lo = r_diff * $signed({1'b0, r_factor[15:0]});

    assign y_sum = 60'(r_y_old) + 60'(r_p_hi) + 60'(r_p_lo) + 60'(r_noise);

    always_comb begin
        if (y_sum > 60'(Y_MAX)) begin
            y_clamp = Y_MAX;
        end else if (y_sum < 60'(Y_MIN)) begin
            y_clamp = Y_MIN;
        end else begin
            y_clamp = y_sum[24:0];
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RESET;
            r_inv_tau <= INV_TAU_RESET;
            r_amp     <= NOISE_RESET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_GAIN:    r_gain    <= i_cfg_data;
                CFG_INV_TAU: r_inv_tau <= i_cfg_data;
                CFG_NOISE:   r_amp     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i] <= '0;
                r_lcg[i]   <= fope_seed(i);
            end
        end else begin
            if (i_cmd.clear_all) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_level[i] <= '0;
                end
            end
            if (i_cmd.do_sum) begin
                r_level[ch_idx] <= 26'(y_clamp);
            end
            if (i_cmd.do_diff) begin
                r_lcg[ch_idx] <= r_lcg_next;
            end
        end
    end

    // pipeline of one step
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in     <= i_in_item;
            r_reject <= o_status.is_reject;
            r_zero   <= o_status.is_clear || o_status.is_reject;
        end
        if (i_cmd.do_mul) begin
            r_ku       <= ku_prod[55:16];
            r_factor   <= factor_prod[47:16];
            r_lcg_next <= lcg_next;
            r_y_old    <= r_level[ch_idx];
        end
        if (i_cmd.do_diff) begin
            r_diff  <= 41'(r_ku) - 41'(r_y_old);
            r_noise <= noise_prod[40:15];
        end
        if (i_cmd.do_prod) begin
            r_p_hi <= p_hi;
            r_p_lo <= p_lo[57:16];
        end
        if (i_cmd.do_sum) begin
            r_y_new <= y_clamp;
        end
        if (i_cmd.load_out) begin
            if (r_zero) begin
                r_out_item.plant_output <= '0;
                r_out_item.rejected     <= r_reject;
            end else begin
                r_out_item.plant_output <= r_y_new;
                r_out_item.rejected     <= 1'b0;
            end
        end
    end

    assign o_out_item = r_out_item;

endmodule
`default_nettype wire

FILE: tb/first_order_plant_emulator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_order_plant_emulator_unit_test
// self-checking bench for the multi-channel first-order lag plant emulator:
// a queue-fed driver offers step, clear and refused requests under random
// gaps, a monitor predicts each accepted request in q.16 fixed point and
// compares every returned result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module first_order_plant_emulator_unit_test;
    import fope_pkg::*;

    localparam int      CHANNELS       = 3;
    localparam int      CLK_PERIOD     = 10;
    localparam int      IDLE_PCT       = 17;      // chance of a gap per cycle, percent
    localparam int      HOLD_CYCLES    = 300;     // long receiver hold-off
    localparam int      WATCHDOG_LIMIT = 2000;    // cycles with no handshake at all
    localparam int      PHASES         = 8;
    localparam int      PHASE_ITEMS    = 210;
    localparam longint  Y_LIMIT        = 64'sd13107200;
    localparam longint  DELTA_SAT      = 64'sd1 <<< 40;
    // index past the three registers, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // bench signals, the driven ones known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              request   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // ------------------------------------------------------------------
    // plant predictor state and its copy of the registers
    // ------------------------------------------------------------------
    longint                       level     [CHANNELS];
    logic [31:0]                  lcg_state [CHANNELS];
    logic signed [CFG_DATA_W-1:0] gain_k    = GAIN_RESET;
    logic [CFG_DATA_W-1:0]        inv_tau   = INV_TAU_RESET;
    logic [CFG_DATA_W-1:0]        noise_amp = NOISE_RESET;

    t_in_item  pending     [$];   // requests waiting for the driver
    t_out_item results_due [$];   // predicted results, oldest first
    t_out_item want;

    int  errors        = 0;
    int  idle_cycles   = 0;
    int  hold_left     = 0;
    bit  hold_taken    = 1'b0;
    bit  hold_request  = 1'b0;    // raised once by the sequence to start the hold-off
    bit  steady        = 1'b0;    // no gaps on either side while set
    int  phase;

    always #(CLK_PERIOD / 2) clk = ~clk;

    first_order_plant_emulator_unit #(
        .CHANNELS (CHANNELS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (request),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // plant prediction for one accepted request
    // ------------------------------------------------------------------
    function automatic t_out_item plant_step(input t_in_item req);
        t_out_item         res;
        longint            ku;
        longint            diff;
        longint            delta;
        longint            sample;
        longint            noise_term;
        longint            y;
        longint unsigned   factor;
        longint unsigned   mag;
        logic [31:0]       lcg;
        int                c;
        res = '0;
        // clear zeroes every output, noise generators keep running state
        if (req.operation == OP_CLEAR) begin
            for (c = 0; c < CHANNELS; c++)
                level[c] = 0;
            return res;
        end
        // refused request: missing channel or zero time step, nothing moves
        if (req.channel >= CHANNELS || req.time_step == '0) begin
            res.rejected = 1'b1;
            return res;
        end
        ku     = (longint'(gain_k) * longint'($signed(req.drive))) >>> 16;
        diff   = ku - level[req.channel];
        factor = ({40'd0, req.time_step} * {40'd0, inv_tau}) >> 16;
        mag    = (diff < 0) ? longint'(-diff) : longint'(diff);
        if (factor != 0 && mag > (64'd1 << 62) / factor) begin
            // product too large, step saturates and the clamp takes over
            if (diff < 0)
                delta = -DELTA_SAT;
            else
                delta = DELTA_SAT;
        end else begin
            mag = mag * factor;
            if (diff < 0)
                delta = -longint'((mag + 64'hFFFF) >> 16);
            else
                delta = longint'(mag >> 16);
        end
        // generator advances on every step that is not refused, even at zero amplitude
        lcg                    = lcg_state[req.channel] * LCG_MUL + LCG_ADD;
        lcg_state[req.channel] = lcg;
        sample                 = longint'(lcg[23:8]) - 32768;
        noise_term             = (longint'(noise_amp) * sample) >>> 15;
        y = level[req.channel] + delta + noise_term;
        if (y > Y_LIMIT)
            y = Y_LIMIT;
        if (y < -Y_LIMIT)
            y = -Y_LIMIT;
        level[req.channel] = y;
        res.plant_output   = y[24:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random request: mostly in-range steps with small drive and dt,
    // some full-range values, refused channels, zero dt and clears
    // ------------------------------------------------------------------
    function automatic t_in_item random_request();
        t_in_item req;
        req.operation = ($urandom_range(99) < 3) ? OP_CLEAR : OP_STEP;
        if ($urandom_range(9) == 0)
            req.channel = 3'($urandom_range(7, CHANNELS));
        else
            req.channel = 3'($urandom_range(CHANNELS - 1));
        if ($urandom_range(3) == 0)
            req.drive = $urandom;
        else
            req.drive = $urandom_range(33554431) - 32'd16777216;   // about +/-256.0
        case ($urandom_range(19))
            0:       req.time_step = '0;
            1, 2, 3: req.time_step = 24'($urandom_range(24'hFFFFFF));
            default: req.time_step = 24'($urandom_range(4095, 1));
        endcase
        return req;
    endfunction

    task automatic push_request(input logic op, input logic [2:0] ch,
                                input logic [31:0] drive, input logic [23:0] dt);
        t_in_item req;
        req.operation = op;
        req.channel   = ch;
        req.drive     = drive;
        req.time_step = dt;
        pending.push_back(req);
    endtask

    // register write over the config channel, predictor follows on the handshake
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_GAIN:    gain_k    = value;
            CFG_INV_TAU: inv_tau   = value;
            CFG_NOISE:   noise_amp = value;
            default:     ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_for_drain();
        do @(negedge clk);
        while (pending.size() != 0 || in_valid || results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // driver: takes the next request from the queue, with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                request  <= pending.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks results first, then predicts the request taken at
    // this edge, so a result is never checked against that request's prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with no request outstanding, actual %0d/%0b",
                             $time, result.plant_output, result.rejected);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (result.plant_output !== want.plant_output) begin
                        $display("%0t: plant_output expected %0d actual %0d",
                                 $time, want.plant_output, result.plant_output);
                        errors++;
                    end
                    if (result.rejected !== want.rejected) begin
                        $display("%0t: rejected expected %0b actual %0b",
                                 $time, want.rejected, result.rejected);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                results_due.push_back(plant_step(request));
            // receiver side: one long hold-off on request, else random stalls
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
            end
            out_ready <= hold_left <= 1 && !(hold_request && !hold_taken)
                         && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake means the block hung
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("first_order_plant_emulator_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed requests, then phases of register
    // settings each followed by a burst of random requests
    // ------------------------------------------------------------------
    initial begin
        for (int c = 0; c < CHANNELS; c++)
            level[c] = 0;
        lcg_state[0] = 32'h1234ABCD;
        lcg_state[1] = 32'h5678DEFE;
        lcg_state[2] = 32'h9ABC1234;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at reset settings (gain 1.0, 1/tau 1.0, no noise)
        push_request(OP_STEP,  3'd0, 32'h00000000, 24'h000001);   // smallest dt
        push_request(OP_STEP,  3'd0, 32'h7FFFFFFF, 24'hFFFFFF);   // top drive, top dt
        push_request(OP_STEP,  3'd1, 32'h80000000, 24'hFFFFFF);   // bottom drive
        push_request(OP_STEP,  3'd2, 32'h00010000, 24'h008000);   // 1.0 for 0.5 s
        push_request(OP_STEP,  3'd1, 32'h00000001, 24'h000001);
        push_request(OP_STEP,  3'd2, 32'hFFFFFFFF, 24'h800000);
        push_request(OP_STEP,  3'd3, 32'h00010000, 24'h000100);   // first missing channel
        push_request(OP_STEP,  3'd7, 32'h00010000, 24'h000100);   // last missing channel
        push_request(OP_STEP,  3'd0, 32'h00010000, 24'h000000);   // zero time step
        push_request(OP_STEP,  3'd7, 32'hFFFFFFFF, 24'h000000);   // both refusals at once
        push_request(OP_CLEAR, 3'd7, $urandom,     24'h000000);   // clear ignores the rest
        push_request(OP_STEP,  3'd0, 32'hFFFF0000, 24'h010000);   // -1.0 after clear
        push_request(OP_CLEAR, 3'd7, 32'hFFFFFFFF, 24'hFFFFFF);
        push_request(OP_STEP,  3'd2, 32'h00020000, 24'h000400);
        wait_for_drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    // every register at its top value
                    write_register(CFG_GAIN,    24'h7FFFFF);
                    write_register(CFG_INV_TAU, 24'hFFFFFF);
                    write_register(CFG_NOISE,   24'hFFFFFF);
                end
                1: begin
                    // most negative gain, no motion, no noise, plus a dead index
                    write_register(CFG_GAIN,    24'h800000);
                    write_register(CFG_INV_TAU, 24'h000000);
                    write_register(CFG_NOISE,   24'h000000);
                    write_register(CFG_UNUSED,  24'($urandom));
                end
                2: begin
                    write_register(CFG_GAIN,    24'h000000);
                    write_register(CFG_INV_TAU, 24'h080000);
                    write_register(CFG_NOISE,   24'h000001);
                end
                default: begin
                    if ($urandom_range(3) == 0)
                        write_register(CFG_GAIN, 24'($urandom));
                    else
                        write_register(CFG_GAIN, 24'($urandom_range(524287) - 24'd262144));
                    if ($urandom_range(3) == 0)
                        write_register(CFG_INV_TAU, 24'($urandom));
                    else
                        write_register(CFG_INV_TAU, 24'($urandom_range(24'h400000, 1)));
                    case ($urandom_range(3))
                        0:       write_register(CFG_NOISE, 24'h000000);
                        1:       write_register(CFG_NOISE, 24'($urandom));
                        default: write_register(CFG_NOISE, 24'($urandom_range(24'h040000)));
                    endcase
                end
            endcase
            // extreme settings drive the diff*factor product into saturation
            if (phase == 0) begin
                push_request(OP_STEP, 3'd0, 32'h7FFFFFFF, 24'hFFFFFF);
                push_request(OP_STEP, 3'd1, 32'h80000000, 24'hFFFFFF);
            end
            steady = (phase == 4);
            // receiver holds off while the driver keeps offering, block backs up
            if (phase == 3)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS) pending.push_back(random_request());
            wait_for_drain();
        end

        steady = 1'b0;
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("first_order_plant_emulator_unit: match");
        else
            $display("first_order_plant_emulator_unit: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fope_pkg.sv
hw/rtl/fope_ctrl.sv
hw/rtl/fope_dp.sv
hw/rtl/first_order_plant_emulator_unit.sv
tb/first_order_plant_emulator_unit_test.sv
